@@ hdl/bucket_directory_search_unit_defines.svh @@
// assertion macros for the bucket directory search unit
`ifndef BUCKET_DIRECTORY_SEARCH_UNIT_DEFINES_SVH
`define BUCKET_DIRECTORY_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BDS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bds assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define BDS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bds assertion failed");

`endif

@@ hdl/bds_pkg.sv @@
// shared types and constants for the bucket directory search unit
package bds_pkg;

  localparam int unsigned MAX_ENTRIES = 4096;
  localparam int unsigned DIR_BITS    = 12;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned POS_W       = 12;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned DIR_WORDS   = (1 << DIR_BITS) + 1;
  localparam int unsigned DIR_AW      = $clog2(DIR_WORDS);
  localparam int unsigned FILL_W      = $clog2(DIR_WORDS + 1);

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_BUILD = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  localparam logic [1:0] ST_HIT       = 2'd0;
  localparam logic [1:0] ST_MISS      = 2'd1;
  localparam logic [1:0] ST_NOT_BUILT = 2'd2;
  localparam logic [1:0] ST_MISS_ERR  = 2'd3;

  typedef enum logic [1:0] {
    RES_HIT,
    RES_MISS,
    RES_NOT_BUILT
  } res_kind_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
  } in_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] position;
  } out_req_t;

  typedef struct packed {
    logic      capture;
    logic      tgt_build;
    logic      set_err;
    logic      fill_step;
    logic      commit;
    logic      set_ready;
    logic      clear;
    logic      dir_rd_hi;
    logic      take_start;
    logic      take_end;
    logic      scan_issue;
    logic      res_load;
    res_kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    logic load_bad;
    logic ready;
    logic fill_pending;
    logic scan_more;
    logic cmp_valid;
    logic match;
    logic out_busy;
  } sts_t;

endpackage

@@ hdl/bds_ram.sv @@
// generic single write port ram with registered read
module bds_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/bds_datapath.sv @@
// datapath: key table, bucket directory, counters, scan and result register
module bds_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  bds_pkg::in_req_t in_req,
  input  bds_pkg::cmd_t    cmd,
  output bds_pkg::sts_t    sts,
  output logic             out_valid,
  input  logic             out_stall,
  output bds_pkg::out_req_t out_req
);

  logic [bds_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [bds_pkg::FILL_W-1:0] filled_r, filled_nxt;
  logic [bds_pkg::FILL_W-1:0] target_r, target_nxt;
  logic [bds_pkg::KEY_W-1:0]  prev_r, prev_nxt;
  logic                       ready_r, ready_nxt;
  logic                       err_r, err_nxt;
  logic [bds_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [bds_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic [bds_pkg::CNT_W-1:0]  end_r, end_nxt;
  logic [bds_pkg::IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic                       cmp_valid_r, cmp_valid_nxt;
  logic                       out_valid_r, out_valid_nxt;
  bds_pkg::out_req_t          out_req_r, out_req_nxt;

  logic [bds_pkg::DIR_BITS-1:0] in_bucket;
  logic [bds_pkg::DIR_BITS-1:0] key_bucket;
  logic [bds_pkg::DIR_AW-1:0]   dir_raddr;
  logic [bds_pkg::CNT_W-1:0]    dir_rdata;
  logic [bds_pkg::KEY_W-1:0]    key_rdata;

  assign in_bucket  = in_req.key[bds_pkg::KEY_W-1 -: bds_pkg::DIR_BITS];
  assign key_bucket = key_r[bds_pkg::KEY_W-1 -: bds_pkg::DIR_BITS];
  assign dir_raddr  = cmd.dir_rd_hi ? bds_pkg::DIR_AW'(key_bucket) + bds_pkg::DIR_AW'(1)
                                    : bds_pkg::DIR_AW'(key_bucket);

  bds_ram #(
    .WIDTH (bds_pkg::CNT_W),
    .DEPTH (bds_pkg::DIR_WORDS)
  ) u_dir_ram (
    .clk   (clk),
    .we    (cmd.fill_step),
    .waddr (filled_r[bds_pkg::DIR_AW-1:0]),
    .wdata (count_r),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  bds_ram #(
    .WIDTH (bds_pkg::KEY_W),
    .DEPTH (bds_pkg::MAX_ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (count_r[bds_pkg::IDX_W-1:0]),
    .wdata (key_r),
    .raddr (idx_r[bds_pkg::IDX_W-1:0]),
    .rdata (key_rdata)
  );

  always_comb begin
    sts.load_bad     = ready_r || (count_r >= bds_pkg::CNT_W'(bds_pkg::MAX_ENTRIES)) ||
                       ((count_r != '0) && (in_req.key < prev_r));
    sts.ready        = ready_r;
    sts.fill_pending = filled_r < target_r;
    sts.scan_more    = idx_r < end_r;
    sts.cmp_valid    = cmp_valid_r;
    sts.match        = cmp_valid_r && (key_rdata == key_r);
    sts.out_busy     = out_valid_r && out_stall;
  end

  always_comb begin
    count_nxt     = count_r;
    filled_nxt    = filled_r;
    target_nxt    = target_r;
    prev_nxt      = prev_r;
    ready_nxt     = ready_r;
    err_nxt       = err_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    end_nxt       = end_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_valid_nxt = cmd.scan_issue;
    out_valid_nxt = out_valid_r && out_stall;
    out_req_nxt   = out_req_r;

    if (cmd.capture) begin
      key_nxt    = in_req.key;
      target_nxt = cmd.tgt_build ? bds_pkg::FILL_W'(bds_pkg::DIR_WORDS)
                                 : bds_pkg::FILL_W'(in_bucket) + bds_pkg::FILL_W'(1);
    end
    if (cmd.set_err) begin
      err_nxt = 1'b1;
    end
    if (cmd.fill_step) begin
      filled_nxt = filled_r + bds_pkg::FILL_W'(1);
    end
    if (cmd.commit) begin
      count_nxt = count_r + bds_pkg::CNT_W'(1);
      prev_nxt  = key_r;
    end
    if (cmd.set_ready) begin
      ready_nxt = 1'b1;
    end
    if (cmd.take_start) begin
      idx_nxt = dir_rdata;
    end
    if (cmd.take_end) begin
      end_nxt = (dir_rdata < count_r) ? dir_rdata : count_r;
    end
    if (cmd.scan_issue) begin
      idx_nxt     = idx_r + bds_pkg::CNT_W'(1);
      cmp_idx_nxt = idx_r[bds_pkg::IDX_W-1:0];
    end
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
      case (cmd.res_kind)
        bds_pkg::RES_HIT: begin
          out_req_nxt.status   = bds_pkg::ST_HIT;
          out_req_nxt.position = bds_pkg::POS_W'(cmp_idx_r);
        end
        bds_pkg::RES_MISS: begin
          out_req_nxt.status   = err_r ? bds_pkg::ST_MISS_ERR : bds_pkg::ST_MISS;
          out_req_nxt.position = '0;
        end
        default: begin
          out_req_nxt.status   = bds_pkg::ST_NOT_BUILT;
          out_req_nxt.position = '0;
        end
      endcase
    end
    if (cmd.clear) begin
      count_nxt  = '0;
      filled_nxt = '0;
      target_nxt = '0;
      prev_nxt   = '0;
      ready_nxt  = 1'b0;
      err_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      filled_r    <= '0;
      target_r    <= '0;
      prev_r      <= '0;
      ready_r     <= 1'b0;
      err_r       <= 1'b0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      filled_r    <= filled_nxt;
      target_r    <= target_nxt;
      prev_r      <= prev_nxt;
      ready_r     <= ready_nxt;
      err_r       <= err_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r     <= key_nxt;
    idx_r     <= idx_nxt;
    end_r     <= end_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    out_req_r <= out_req_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule

@@ hdl/bds_ctrl.sv @@
// controller: sequences loads, directory fills, queries and result hand-off
module bds_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  bds_pkg::mode_t    in_mode,
  input  bds_pkg::sts_t     sts,
  output bds_pkg::cmd_t     cmd,
  output logic              in_stall
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LFILL,
    S_BFILL,
    S_QLO,
    S_QHI,
    S_QEND,
    S_QSCAN,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  bds_pkg::res_kind_t kind_r, kind_nxt;

  always_comb begin
    cmd          = '0;
    cmd.res_kind = kind_r;
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            bds_pkg::MODE_LOAD: begin
              if (sts.load_bad) begin
                cmd.set_err = 1'b1;
              end else begin
                cmd.capture = 1'b1;
                state_nxt   = S_LFILL;
              end
            end
            bds_pkg::MODE_BUILD: begin
              cmd.capture   = 1'b1;
              cmd.tgt_build = 1'b1;
              state_nxt     = S_BFILL;
            end
            bds_pkg::MODE_QUERY: begin
              if (sts.ready) begin
                cmd.capture = 1'b1;
                state_nxt   = S_QLO;
              end else begin
                kind_nxt  = bds_pkg::RES_NOT_BUILT;
                state_nxt = S_DONE;
              end
            end
            default: begin
              cmd.clear = 1'b1;
            end
          endcase
        end
      end
      S_LFILL: begin
        if (sts.fill_pending) begin
          cmd.fill_step = 1'b1;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_BFILL: begin
        if (sts.fill_pending) begin
          cmd.fill_step = 1'b1;
        end else begin
          cmd.set_ready = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_QLO: begin
        state_nxt = S_QHI;
      end
      S_QHI: begin
        cmd.dir_rd_hi  = 1'b1;
        cmd.take_start = 1'b1;
        state_nxt      = S_QEND;
      end
      S_QEND: begin
        cmd.take_end = 1'b1;
        state_nxt    = S_QSCAN;
      end
      S_QSCAN: begin
        if (sts.match) begin
          kind_nxt  = bds_pkg::RES_HIT;
          state_nxt = S_DONE;
        end else if (sts.scan_more) begin
          cmd.scan_issue = 1'b1;
        end else if (!sts.cmp_valid) begin
          kind_nxt  = bds_pkg::RES_MISS;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= bds_pkg::RES_MISS;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

@@ hdl/bucket_directory_search_unit.sv @@
// top level of the bucket directory search unit
// load: fills directory words up to the key's bucket, then commits the key
// build: fills the remaining directory words, then marks the directory ready
// query: reads the low and high directory words of the key's bucket, then scans that range
// until a match or its end; before build, a not-built result; waits for a free output
// reset clears control state only; memory contents stay undefined, no clearing pass
`include "bucket_directory_search_unit_defines.svh"

module bucket_directory_search_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bds_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output bds_pkg::out_req_t out_req
);

  bds_pkg::cmd_t cmd;
  bds_pkg::sts_t sts;

  bds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (bds_pkg::mode_t'(in_req.mode)),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  bds_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  // a built directory has every word written
  `BDS_ASSERT_IMP(a_ready_filled, sts.ready, !sts.fill_pending)
  // scan reads stay inside the bucket range
  `BDS_ASSERT_IMP(a_scan_in_range, cmd.scan_issue, sts.scan_more)
  // a stalled result is never overwritten
  `BDS_ASSERT_IMP(a_no_overwrite, cmd.res_load, !(out_valid && out_stall))
  // a loaded result is presented next cycle
  `BDS_ASSERT_NXT(a_result_shown, cmd.res_load, out_valid)

endmodule

@@ dv/bucket_directory_search_unit_tb.sv @@
// self-checking testbench for the bucket directory search unit: directed and random table phases
module bucket_directory_search_unit_tb;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 4200;
  localparam int unsigned RANDOM_REQUESTS = 1340;
  localparam int unsigned DENSE_KEYS = 400;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  bds_pkg::in_req_t  in_req = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  bds_pkg::out_req_t out_req;

  bucket_directory_search_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  // predicted table state
  logic [bds_pkg::KEY_W-1:0]  key_tab [0:bds_pkg::MAX_ENTRIES-1];
  logic [bds_pkg::CNT_W-1:0]  dir_tab [0:bds_pkg::DIR_WORDS-1];
  logic [bds_pkg::CNT_W-1:0]  entry_cnt = '0;
  logic [bds_pkg::FILL_W-1:0] words_filled = '0;
  logic [bds_pkg::KEY_W-1:0]  last_key = '0;
  logic                       dir_ready = 1'b0;
  logic                       load_err = 1'b0;

  bds_pkg::out_req_t lookup_answers [$];
  bds_pkg::out_req_t oldest_answer;
  int unsigned       fail_count = 0;
  int unsigned       requests_sent = 0;
  int unsigned       hit_total = 0;
  int unsigned       miss_count = 0;
  int unsigned       unbuilt_count = 0;
  int unsigned       cycle_count = 0;
  logic              steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 20);
  end

  task automatic fill_directory_to(input int unsigned upto);
    while (words_filled < upto && words_filled < bds_pkg::DIR_WORDS) begin
      dir_tab[words_filled] = entry_cnt;
      words_filled++;
    end
  endtask

  task automatic predict_search(input bds_pkg::mode_t m, input logic [bds_pkg::KEY_W-1:0] k);
    logic [bds_pkg::DIR_BITS-1:0] bucket;
    int unsigned                  lo;
    int unsigned                  hi;
    logic                         found;
    bds_pkg::out_req_t            answer;
    bucket = k[bds_pkg::KEY_W-1 -: bds_pkg::DIR_BITS];
    case (m)
      bds_pkg::MODE_LOAD: begin
        if (dir_ready || entry_cnt >= bds_pkg::MAX_ENTRIES ||
            (entry_cnt != 0 && k < last_key)) begin
          load_err = 1'b1;
        end else begin
          fill_directory_to(int'(bucket) + 1);
          key_tab[entry_cnt] = k;
          entry_cnt++;
          last_key = k;
        end
      end
      bds_pkg::MODE_BUILD: begin
        fill_directory_to(bds_pkg::DIR_WORDS);
        dir_ready = 1'b1;
      end
      bds_pkg::MODE_CLEAR: begin
        entry_cnt = '0;
        words_filled = '0;
        last_key = '0;
        dir_ready = 1'b0;
        load_err = 1'b0;
      end
      default: begin
        answer = '0;
        if (!dir_ready) begin
          answer.status = bds_pkg::ST_NOT_BUILT;
        end else begin
          lo = dir_tab[bucket];
          hi = dir_tab[int'(bucket) + 1];
          if (hi > entry_cnt) hi = entry_cnt;
          found = 1'b0;
          for (int unsigned i = lo; i < hi && !found; i++) begin
            if (key_tab[i] == k) begin
              found = 1'b1;
              answer.position = i[bds_pkg::POS_W-1:0];
            end
          end
          answer.status = found ? bds_pkg::ST_HIT :
                          (load_err ? bds_pkg::ST_MISS_ERR : bds_pkg::ST_MISS);
        end
        lookup_answers.push_back(answer);
      end
    endcase
  endtask

  task automatic send_request(input bds_pkg::mode_t m, input logic [bds_pkg::KEY_W-1:0] k);
    while (!steady && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{mode: m, key: k};
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_search(m, k);
    requests_sent++;
  endtask

  task automatic wait_for_answers;
    in_valid <= 1'b0;
    do @(posedge clk); while (lookup_answers.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (lookup_answers.size() == 0) begin
        $error("unexpected result: status %0d position %0d", out_req.status, out_req.position);
        fail_count++;
      end else begin
        oldest_answer = lookup_answers.pop_front();
        if (out_req.status !== oldest_answer.status) begin
          $error("status: expected %0d, actual %0d", oldest_answer.status, out_req.status);
          fail_count++;
        end
        if (out_req.position !== oldest_answer.position) begin
          $error("position: expected %0d, actual %0d", oldest_answer.position,
                 out_req.position);
          fail_count++;
        end
        case (oldest_answer.status)
          bds_pkg::ST_HIT:       hit_total++;
          bds_pkg::ST_NOT_BUILT: unbuilt_count++;
          default:               miss_count++;
        endcase
      end
    end
  end

  // empty table, before and after build
  task automatic test_empty_table;
    send_request(bds_pkg::MODE_QUERY, 32'h0000_0000);
    send_request(bds_pkg::MODE_BUILD, 32'h0000_0000);
    send_request(bds_pkg::MODE_QUERY, 32'hFFFF_FFFF);
    send_request(bds_pkg::MODE_CLEAR, 32'h0000_0000);
  endtask

  // extreme keys, duplicates, first and last bucket, repeated build
  task automatic test_extreme_keys;
    send_request(bds_pkg::MODE_LOAD, 32'h0000_0000);
    send_request(bds_pkg::MODE_LOAD, 32'h0000_0000);
    send_request(bds_pkg::MODE_LOAD, 32'h0010_0000);
    send_request(bds_pkg::MODE_LOAD, 32'h7FFF_FFFF);
    send_request(bds_pkg::MODE_LOAD, 32'h8000_0000);
    send_request(bds_pkg::MODE_LOAD, 32'hFFFF_FFFE);
    send_request(bds_pkg::MODE_LOAD, 32'hFFFF_FFFF);
    send_request(bds_pkg::MODE_LOAD, 32'hFFFF_FFFF);
    send_request(bds_pkg::MODE_QUERY, 32'h8000_0000);
    send_request(bds_pkg::MODE_BUILD, 32'h0000_0000);
    send_request(bds_pkg::MODE_BUILD, 32'hFFFF_FFFF);
    send_request(bds_pkg::MODE_QUERY, 32'h0000_0000);
    send_request(bds_pkg::MODE_QUERY, 32'hFFFF_FFFF);
    send_request(bds_pkg::MODE_QUERY, 32'h1234_5678);
  endtask

  // load after build, out-of-order load, sticky error cleared by clear
  task automatic test_load_errors;
    send_request(bds_pkg::MODE_LOAD, 32'h1234_5678);
    send_request(bds_pkg::MODE_QUERY, 32'h1234_5678);
    send_request(bds_pkg::MODE_CLEAR, 32'hFFFF_FFFF);
    send_request(bds_pkg::MODE_LOAD, 32'h0000_0005);
    send_request(bds_pkg::MODE_LOAD, 32'h0000_0003);
    send_request(bds_pkg::MODE_BUILD, 32'h0000_0000);
    send_request(bds_pkg::MODE_QUERY, 32'h0000_0003);
  endtask

  // dense table, one key per bucket, repeated last key, no idling on either side
  task automatic test_dense_table;
    logic [bds_pkg::KEY_W-1:0] k;
    steady = 1'b1;
    send_request(bds_pkg::MODE_CLEAR, $urandom);
    for (int unsigned i = 0; i < DENSE_KEYS; i++) begin
      k = {i[bds_pkg::DIR_BITS-1:0], 20'(($urandom_range(0, 20'hFFFFF)))};
      send_request(bds_pkg::MODE_LOAD, k);
    end
    send_request(bds_pkg::MODE_LOAD, key_tab[DENSE_KEYS-1]);
    send_request(bds_pkg::MODE_BUILD, $urandom);
    wait_for_answers();
    send_request(bds_pkg::MODE_QUERY, key_tab[DENSE_KEYS-1]);
    send_request(bds_pkg::MODE_QUERY, key_tab[0]);
    repeat (40) begin
      if ($urandom_range(1) == 0)
        send_request(bds_pkg::MODE_QUERY, key_tab[$urandom_range(0, DENSE_KEYS-1)]);
      else send_request(bds_pkg::MODE_QUERY, $urandom);
    end
    steady = 1'b0;
  endtask

  // random tables of varying density, with noise loads and early lookups
  task automatic test_random_tables;
    int unsigned               first_request;
    int unsigned               n;
    int unsigned               lookups;
    int unsigned               pick;
    logic [bds_pkg::KEY_W-1:0] spread;
    logic [bds_pkg::KEY_W-1:0] base;
    logic [bds_pkg::KEY_W-1:0] sorted_keys [$];
    first_request = requests_sent;
    while (requests_sent - first_request < RANDOM_REQUESTS) begin
      if ($urandom_range(9) != 0) send_request(bds_pkg::MODE_CLEAR, $urandom);
      n = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      case ($urandom_range(2))
        0:       spread = 32'h0000_0FFF;
        1:       spread = 32'h003F_FFFF;
        default: spread = 32'hFFFF_FFFF;
      endcase
      base = (spread == 32'hFFFF_FFFF) ? '0 : $urandom_range(0, 32'hFFFF_FFFF - spread);
      sorted_keys.delete();
      repeat (n) sorted_keys.push_back(base + $urandom_range(0, spread));
      sorted_keys.sort();
      foreach (sorted_keys[i]) begin
        if (entry_cnt != 0 && last_key != 0 && $urandom_range(19) == 0)
          send_request(bds_pkg::MODE_LOAD, $urandom_range(0, last_key - 1));
        if ($urandom_range(29) == 0) send_request(bds_pkg::MODE_QUERY, sorted_keys[i]);
        send_request(bds_pkg::MODE_LOAD, sorted_keys[i]);
        if ($urandom_range(9) == 0) send_request(bds_pkg::MODE_LOAD, sorted_keys[i]);
      end
      send_request(bds_pkg::MODE_BUILD, $urandom);
      if ($urandom_range(4) == 0) send_request(bds_pkg::MODE_BUILD, $urandom);
      if ($urandom_range(3) == 0) wait_for_answers();
      lookups = $urandom_range(5, 40);
      repeat (lookups) begin
        pick = $urandom_range(99);
        if (pick < 5) send_request(bds_pkg::MODE_LOAD, $urandom);
        else if (pick < 8) send_request(bds_pkg::MODE_BUILD, $urandom);
        else if (pick < 60 && entry_cnt != 0)
          send_request(bds_pkg::MODE_QUERY, key_tab[$urandom_range(0, entry_cnt - 1)]);
        else if (pick < 85) send_request(bds_pkg::MODE_QUERY, base + $urandom_range(0, spread));
        else send_request(bds_pkg::MODE_QUERY, $urandom);
      end
      if ($urandom_range(9) == 0) begin
        send_request(bds_pkg::MODE_CLEAR, $urandom);
        send_request(bds_pkg::MODE_QUERY, $urandom);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_extreme_keys();
    test_load_errors();
    test_dense_table();
    test_random_tables();
    wait_for_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    fail_count += lookup_answers.size();
    $display("%0d requests sent; lookups checked: %0d hits, %0d misses, %0d before build",
             requests_sent, hit_total, miss_count, unbuilt_count);
    $display("tables ranged from empty to dense, with out-of-order, duplicate and late loads");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
